// ===== hw/rtl/tlsm_pkg.sv =====
// shared types and constants of the text line substring matcher
package tlsm_pkg;

  localparam int QUERY_MAX_DEF = 32;
  localparam int LINE_MAX_DEF  = 4096;
  localparam int ROW_MAX_DEF   = 65536;

  localparam int BYTE_W     = 8;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 16;
  localparam int TOTAL_W    = 24;
  localparam int QLEN_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QUERY_W    = 4 * CFG_DATA_W;

  localparam logic [TOTAL_W-1:0] TOTAL_LIM = {TOTAL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_0   = 3'd0,
    CFG_QUERY_1   = 3'd1,
    CFG_QUERY_2   = 3'd2,
    CFG_QUERY_3   = 3'd3,
    CFG_QUERY_LEN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              is_line_break;
    logic              new_document;
  } in_word_t;

  typedef struct packed {
    logic               match_found;
    logic [ROW_W-1:0]   match_row;
    logic [COL_W-1:0]   match_column;
    logic [TOTAL_W-1:0] match_total;
  } out_word_t;

endpackage

// ===== hw/rtl/tlsm_cell.sv =====
// one window cell: holds a byte, passes it on and compares it with its query byte
module tlsm_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       clr,
  input  logic [7:0] shift_in,
  input  logic [7:0] query_byte,
  output logic [7:0] byte_q,
  output logic       hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_nxt = clr ? 8'd0 : shift_in;
  // compare against the value the window holds once this word is in
  assign hit      = (byte_nxt == query_byte);
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else if (step) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ===== hw/rtl/text_line_substring_matcher.sv =====
// text line substring matcher: a row of byte cells compared in parallel with the query
// the result of an accepted word is registered in the output register
// throughput: one word per cycle while out_stall does not hold a pending result; every cell compares
// at once and the output register takes a new result while the previous one is being taken
// reset (rst_n low, synchronous): query, window, column, row and match count cleared
module text_line_substring_matcher #(
  parameter int QUERY_MAX = tlsm_pkg::QUERY_MAX_DEF,
  parameter int LINE_MAX  = tlsm_pkg::LINE_MAX_DEF,
  parameter int ROW_MAX   = tlsm_pkg::ROW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tlsm_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tlsm_pkg::out_word_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [tlsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tlsm_pkg::*;

  localparam logic [COL_W-1:0] COL_LIM =
    (LINE_MAX - 1 > 4095) ? {COL_W{1'b1}} : COL_W'(LINE_MAX - 1);
  localparam logic [ROW_W-1:0] ROW_LIM =
    (ROW_MAX - 1 > 65535) ? {ROW_W{1'b1}} : ROW_W'(ROW_MAX - 1);

  logic [CFG_DATA_W-1:0] query_r [4];
  logic [QLEN_W-1:0]     qlen_r;
  logic [COL_W-1:0]      col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]      row_r, row_nxt, row_cur;
  logic [TOTAL_W-1:0]    total_r, total_nxt, total_cur;
  logic                  out_valid_r;
  out_word_t             out_r, out_nxt;

  logic [QUERY_W-1:0]    query_vec;
  logic [7:0]            win [QUERY_MAX];
  logic [QUERY_MAX-1:0]  hits;
  logic [QUERY_MAX-1:0]  mask;
  logic                  in_acc;
  logic                  fresh, brk;
  logic                  qok, found;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign fresh     = in_data.new_document;
  assign brk       = in_data.is_line_break;
  assign query_vec = {query_r[3], query_r[2], query_r[1], query_r[0]};

  // new document clears line and count before the word itself
  assign col_cur   = fresh ? '0 : col_r;
  assign row_cur   = fresh ? '0 : row_r;
  assign total_cur = fresh ? '0 : total_r;

  genvar j;
  generate
    for (j = 0; j < QUERY_MAX; j++) begin : g_cell
      logic [7:0]        shift_in;
      logic [QLEN_W-1:0] qidx;
      logic [7:0]        qbyte;

      if (j == 0) begin : g_head
        assign shift_in = in_data.text_byte;
      end else begin : g_body
        assign shift_in = fresh ? 8'd0 : win[j-1];
      end

      // cell j lines up with query byte qlen-1-j
      assign qidx    = qlen_r - QLEN_W'(1) - QLEN_W'(j);
      assign qbyte   = query_vec[{qidx[4:0], 3'b000} +: 8];
      assign mask[j] = (QLEN_W'(j) < qlen_r);

      tlsm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_acc),
        .clr        (brk),
        .shift_in   (shift_in),
        .query_byte (qbyte),
        .byte_q     (win[j]),
        .hit        (hits[j])
      );
    end
  endgenerate

  always_comb begin
    qok = (qlen_r != '0) && (qlen_r <= QLEN_W'(QUERY_MAX)) &&
          (({1'b0, col_cur} + (COL_W+1)'(1)) >= (COL_W+1)'(qlen_r));
    found = !brk && qok && (&(hits | ~mask));

    total_nxt = total_cur;
    if (found && total_cur != TOTAL_LIM) begin
      total_nxt = total_cur + TOTAL_W'(1);
    end

    row_nxt = row_cur;
    col_nxt = col_cur;
    if (brk) begin
      col_nxt = '0;
      if (row_cur < ROW_LIM) begin
        row_nxt = row_cur + ROW_W'(1);
      end
    end else if (col_cur < COL_LIM) begin
      col_nxt = col_cur + COL_W'(1);
    end

    out_nxt.match_found  = found;
    out_nxt.match_row    = found ? row_cur : '0;
    out_nxt.match_column = found ? (col_cur + COL_W'(1) - COL_W'(qlen_r)) : '0;
    out_nxt.match_total  = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        total_r <= total_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r[0] <= '0;
      query_r[1] <= '0;
      query_r[2] <= '0;
      query_r[3] <= '0;
      qlen_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_QUERY_0:   query_r[0] <= cfg_data;
        CFG_QUERY_1:   query_r[1] <= cfg_data;
        CFG_QUERY_2:   query_r[2] <= cfg_data;
        CFG_QUERY_3:   query_r[3] <= cfg_data;
        CFG_QUERY_LEN: qlen_r     <= cfg_data[QLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
